[rtl/core/qtd_pkg.sv]
// Shared constants and types for the quadtree image decoder.
// Used by qtd_walker and quadtree_image_decoder; depends on nothing.
package qtd_pkg;

  localparam int unsigned MAX_SIZE_LOG = 9;
  localparam int unsigned DEPTH_W      = $clog2(MAX_SIZE_LOG + 1);
  localparam int unsigned IDX_W        = (MAX_SIZE_LOG > 1) ? $clog2(MAX_SIZE_LOG) : 1;
  localparam int unsigned SIZE_W       = 4;
  localparam int unsigned COORD_W      = 9;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned FAULT_W      = 2;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned TDATA_W      = 48;

  localparam logic [BYTE_W-1:0] TAG_SPLIT = 8'h31;
  localparam logic [BYTE_W-1:0] TAG_LEAF  = 8'h30;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_TAG   = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_SPLIT = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  size_log;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [FAULT_W-1:0] fault;
    logic               done;
  } fill_t;

endpackage

[rtl/core/qtd_walker.sv]
// Parser state, child stack and fill command generation for one byte per cycle in which step_i is high.
// Depends on qtd_pkg.
module qtd_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qtd_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic                        step_i,
  input  logic [qtd_pkg::BYTE_W-1:0]  byte_i,
  output logic                        emit_o,
  output qtd_pkg::fill_t              fill_o
);

  localparam logic [1:0] PH_TAG   = 2'd0;
  localparam logic [1:0] PH_RED   = 2'd1;
  localparam logic [1:0] PH_GREEN = 2'd2;
  localparam logic [1:0] PH_BLUE  = 2'd3;

  localparam logic [qtd_pkg::SIZE_W-1:0]  MAX_LOG   = qtd_pkg::SIZE_W'(qtd_pkg::MAX_SIZE_LOG);
  localparam logic [qtd_pkg::DEPTH_W-1:0] MAX_DEPTH = qtd_pkg::DEPTH_W'(qtd_pkg::MAX_SIZE_LOG);

  logic [qtd_pkg::SIZE_W-1:0]   root_q;
  logic [1:0]                   phase_q, phase_d;
  logic [qtd_pkg::COLOR_W-1:0]  red_q, red_d, green_q, green_d;
  logic [qtd_pkg::DEPTH_W-1:0]  depth_q, depth_d;
  logic [1:0]                   stack_q [qtd_pkg::MAX_SIZE_LOG];
  logic [1:0]                   stack_d [qtd_pkg::MAX_SIZE_LOG];

  logic [qtd_pkg::SIZE_W-1:0]   root_eff;
  logic [qtd_pkg::SIZE_W-1:0]   size_cur;
  logic [qtd_pkg::COORD_W-1:0]  pos_x, pos_y;
  logic                         pop_found;
  logic [qtd_pkg::IDX_W-1:0]    pop_idx;
  logic                         emit;
  logic [qtd_pkg::FAULT_W-1:0]  fault;
  logic [qtd_pkg::COLOR_W-1:0]  out_r, out_g, out_b;

  assign root_eff = (root_q > MAX_LOG) ? MAX_LOG : root_q;
  assign size_cur = (qtd_pkg::SIZE_W'(depth_q) < root_eff)
                  ? root_eff - qtd_pkg::SIZE_W'(depth_q) : '0;

  always_comb begin
    logic [qtd_pkg::SIZE_W-1:0] sh;
    pos_x = '0;
    pos_y = '0;
    for (int i = 0; i < qtd_pkg::MAX_SIZE_LOG; i++) begin
      sh = root_eff - qtd_pkg::SIZE_W'(i + 1);
      if ((qtd_pkg::DEPTH_W'(i) < depth_q) && (qtd_pkg::SIZE_W'(i) < root_eff)) begin
        pos_x = pos_x | (qtd_pkg::COORD_W'(stack_q[i][0]) << sh);
        pos_y = pos_y | (qtd_pkg::COORD_W'(stack_q[i][1]) << sh);
      end
    end
  end

  // Deepest level on the current path that still has a sibling to visit.
  always_comb begin
    pop_found = 1'b0;
    pop_idx   = '0;
    for (int i = 0; i < qtd_pkg::MAX_SIZE_LOG; i++) begin
      if ((qtd_pkg::DEPTH_W'(i) < depth_q) && (stack_q[i] != 2'd3)) begin
        pop_found = 1'b1;
        pop_idx   = qtd_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    emit    = 1'b0;
    fault   = qtd_pkg::FAULT_NONE;
    out_r   = '0;
    out_g   = '0;
    out_b   = '0;
    phase_d = phase_q;
    red_d   = red_q;
    green_d = green_q;
    depth_d = depth_q;
    stack_d = stack_q;
    if (step_i) begin
      unique case (phase_q)
        PH_TAG: begin
          if (byte_i == qtd_pkg::TAG_SPLIT) begin
            if ((size_cur == '0) || (depth_q >= MAX_DEPTH)) begin
              emit  = 1'b1;
              fault = qtd_pkg::FAULT_SPLIT;
            end else begin
              stack_d[depth_q[qtd_pkg::IDX_W-1:0]] = 2'd0;
              depth_d = depth_q + 1'b1;
            end
          end else if (byte_i == qtd_pkg::TAG_LEAF) begin
            phase_d = PH_RED;
          end else begin
            emit  = 1'b1;
            fault = qtd_pkg::FAULT_TAG;
          end
        end
        PH_RED: begin
          red_d   = byte_i;
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          green_d = byte_i;
          phase_d = PH_BLUE;
        end
        PH_BLUE: begin
          emit  = 1'b1;
          out_r = red_q;
          out_g = green_q;
          out_b = byte_i;
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
      if (emit) begin
        phase_d = PH_TAG;
        if (pop_found) begin
          depth_d          = qtd_pkg::DEPTH_W'(pop_idx) + 1'b1;
          stack_d[pop_idx] = stack_q[pop_idx] + 2'd1;
        end else begin
          depth_d = '0;
          for (int i = 0; i < qtd_pkg::MAX_SIZE_LOG; i++) begin
            stack_d[i] = 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= MAX_LOG;
      phase_q <= PH_TAG;
      depth_q <= '0;
      for (int i = 0; i < qtd_pkg::MAX_SIZE_LOG; i++) begin
        stack_q[i] <= 2'd0;
      end
    end else if (cfg_we_i) begin
      root_q  <= cfg_wdata_i;
      phase_q <= PH_TAG;
      depth_q <= '0;
      for (int i = 0; i < qtd_pkg::MAX_SIZE_LOG; i++) begin
        stack_q[i] <= 2'd0;
      end
    end else begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      stack_q <= stack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
  end

  assign emit_o          = emit;
  assign fill_o.x        = pos_x;
  assign fill_o.y        = pos_y;
  assign fill_o.size_log = size_cur;
  assign fill_o.red      = out_r;
  assign fill_o.green    = out_g;
  assign fill_o.blue     = out_b;
  assign fill_o.fault    = fault;
  assign fill_o.done     = emit && !pop_found;

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MAX_DEPTH)
    else $error("depth beyond stack size");

  a_depth_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qtd_pkg::SIZE_W'(depth_q) <= root_eff)
    else $error("depth beyond root size");

  a_done_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && fill_o.done |=> depth_q == '0)
    else $error("image end did not return to root");

  a_blue_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PH_BLUE) |=> phase_q == PH_TAG)
    else $error("parser did not return to tag after blue byte");

endmodule

[rtl/core/quadtree_image_decoder.sv]
// Top level of the quadtree image decoder: input stage, walker and output register.
// Depends on qtd_pkg and qtd_walker.
//
// The slave stream carries the encoded image one byte per item in tdata[7:0].
// The master stream carries one fill command per leaf, including skipped
// faulty leaves; tlast marks the leaf that completes the image, and tuser
// holds the fault code.
// The root size register is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce,
// and each write restarts parsing at the root. An accepted byte is held in the
// input register until the walker can take it, and is then decoded by the
// walker; a fill command that it completes is registered in the output
// register, from which the master side presents it.
// The block takes one byte in every cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its command, one more
// byte waits in the input register, and then s_axis_tready_o drops.
// After reset the root size is 512 pixels and the parser expects a tag byte
// at the root, with both registers empty.
module quadtree_image_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qtd_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [qtd_pkg::BYTE_W-1:0]    s_axis_tdata_i,   // data_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // fill_x, fill_y, fill_size_log, red, green, blue, two zero bits
  output logic [qtd_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  output logic [qtd_pkg::FAULT_W-1:0]   m_axis_tuser_o,   // fault
  output logic                          m_axis_tlast_o
);

  logic                        in_valid_q;
  logic [qtd_pkg::BYTE_W-1:0]  in_byte_q;
  logic                        out_valid_q;
  qtd_pkg::fill_t              out_q;
  logic                        advance;
  logic                        emit;
  qtd_pkg::fill_t              fill;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  qtd_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .emit_o      (emit),
    .fill_o      (fill)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && emit) begin
      out_q <= fill;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.blue, out_q.green, out_q.red,
                            out_q.size_log, out_q.y, out_q.x};
  assign m_axis_tuser_o  = out_q.fault;
  assign m_axis_tlast_o  = out_q.done;

endmodule
